// ===== rtl/core/dsb_pkg.sv =====
// Package for the digit-sum-in-base core: sequencer state type and the
// status word passed from the shared divider to the sequencer.
// No dependencies.
package dsb_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_OUT
  } dsb_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsb_div_stat_t;

endpackage

// ===== rtl/core/dsb_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on dsb_pkg for the status struct.
module dsb_div import dsb_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-2:0] dividend,
  input  logic [DATA_WIDTH-2:0] divisor,
  output logic [DATA_WIDTH-2:0] quotient,
  output logic [DATA_WIDTH-2:0] remainder,
  output dsb_div_stat_t         stat
);

  localparam int NW = DATA_WIDTH - 1;
  localparam int CW = $clog2(NW);
  localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] quot;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          fits;

  assign trial = {rem, quot[NW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = !diff[NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      cnt  <= LAST_STEP;
    end else if (busy) begin
      rem  <= fits ? diff[NW-1:0] : trial[NW-1:0];
      quot <= {quot[NW-2:0], fits};
      cnt  <= cnt - 1'b1;
    end
  end

  assign quotient  = quot;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

// ===== rtl/core/digit_sum_in_base_core.sv =====
// Channel | direction | words          | handshake
// in      | input     | number, radix  | in_valid / in_ready
// out     | output    | digit_sum      | out_valid / out_ready
//
// One word takes one divider pass per digit of number in base radix, up to
// DATA_WIDTH - 1 digits, each on the shared bit-serial divider (one quotient
// bit a cycle). A negative or zero number, or a radix below 2, answers 0
// without using the divider. One word is in flight at a time: in_ready is low
// from acceptance until the result word is taken. Reset is synchronous.
// Top level of the digit-sum-in-base core; uses dsb_pkg and dsb_div.
module digit_sum_in_base_core import dsb_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] number,
  input  logic        [DATA_WIDTH-2:0] radix,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [DATA_WIDTH-2:0] digit_sum
);

  localparam int NW = DATA_WIDTH - 1;

  dsb_state_t    state;
  dsb_state_t    state_next;
  logic [NW-1:0] value;
  logic [NW-1:0] base;
  logic [NW-1:0] sum;
  logic          div_start;
  logic [NW-1:0] div_quot;
  logic [NW-1:0] div_rem;
  dsb_div_stat_t div_stat;
  logic          trivial;

  assign trivial = number[DATA_WIDTH-1] || (number[NW-1:0] == '0) || (radix[NW-1:1] == '0);

  dsb_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (value),
    .divisor   (base),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = trivial ? ST_OUT : ST_START;
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          state_next = (div_quot == '0) ? ST_OUT : ST_START;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // hold operands and running sum
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      value <= number[NW-1:0];
      base  <= radix;
      sum   <= '0;
    end else if (state == ST_WAIT && div_stat.done) begin
      value <= div_quot;
      sum   <= sum + div_rem;
    end
  end

  assign digit_sum = sum;

endmodule

// ===== rtl/core/dsb_check.sv =====
// Port-level checker for digit_sum_in_base_core, bound to the top level.
// Depends on the top level's ports only.
module dsb_check #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [DATA_WIDTH-1:0] number,
  input logic        [DATA_WIDTH-2:0] radix,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic        [DATA_WIDTH-2:0] digit_sum
);

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not idle after result word taken");

  a_negative_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && number[DATA_WIDTH-1] |=> out_valid && digit_sum == '0)
    else $error("negative number did not give zero at once");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_sum))
    else $error("result word dropped or changed while stalled");

endmodule

bind digit_sum_in_base_core dsb_check #(.DATA_WIDTH(DATA_WIDTH)) u_dsb_check (.*);
